// File: hw/rtl/ocvsoc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocvsoc_pkg
// Types, breakpoint table and per-segment constants of the voltage to
// charge interpolator.
// ----------------------------------------------------------------------------
package ocvsoc_pkg;

    localparam int MV_W     = 16;
    localparam int SOC_W    = 10;
    localparam int ROM_LEN  = 10;
    localparam int SEG_W    = 4;
    // widths below follow from the table: span at most 300, rise at most 150
    localparam int D_W      = 9;
    localparam int SPAN_W   = 9;
    localparam int RISE_W   = 8;
    localparam int RECIP_W  = 11;
    localparam int RECIP_SH = 16;
    localparam int P_W      = D_W + RISE_W;
    localparam int T_W      = P_W + RECIP_W;
    localparam int Q_W      = 9;

    localparam logic [SOC_W-1:0] SOC_FULL = SOC_W'(1000);

    typedef logic [MV_W-1:0]   t_mv;
    typedef logic [SOC_W-1:0]  t_soc;
    typedef logic [SEG_W-1:0]  t_seg;

    typedef enum logic [1:0] {
        CLS_LOW  = 2'd0,
        CLS_SEG  = 2'd1,
        CLS_FULL = 2'd2
    } t_cls;

    // one classified word between front and back
    typedef struct packed {
        t_cls             cls;
        t_seg             seg;
        logic [D_W-1:0]   d;
    } t_seg_req;

    localparam int REQ_W = $bits(t_seg_req);

    localparam t_mv BP_MV [ROM_LEN] = '{
        16'd3000, 16'd3300, 16'd3500, 16'd3650, 16'd3750,
        16'd3850, 16'd3950, 16'd4050, 16'd4150, 16'd4200
    };

    localparam t_soc BP_SOC [ROM_LEN] = '{
        10'd0,   10'd50,  10'd120, 10'd250, 10'd400,
        10'd550, 10'd700, 10'd850, 10'd950, 10'd1000
    };

    // indexed by the upper breakpoint of a segment, entry 0 unused
    localparam logic [SPAN_W-1:0] SEG_SPAN [ROM_LEN] = '{
        9'd0,   9'd300, 9'd200, 9'd150, 9'd100,
        9'd100, 9'd100, 9'd100, 9'd100, 9'd50
    };

    localparam logic [RISE_W-1:0] SEG_RISE [ROM_LEN] = '{
        8'd0,   8'd50,  8'd70,  8'd130, 8'd150,
        8'd150, 8'd150, 8'd150, 8'd100, 8'd50
    };

    // floor(2^16 / span), the quotient estimate is low by at most one
    localparam logic [RECIP_W-1:0] SEG_RECIP [ROM_LEN] = '{
        11'd0,   11'd218, 11'd327, 11'd436, 11'd655,
        11'd655, 11'd655, 11'd655, 11'd655, 11'd1310
    };

endpackage

// File: hw/rtl/ocv_to_soc_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocv_to_soc_interpolator
// Cell open-circuit voltage (mV) to state of charge (0.1 %), piecewise
// linear over a fixed ten-point breakpoint table.
//
// Input channel: push / full with i_cell_voltage_mv; a word is taken on a
// clock edge with push high and full low. Result channel: empty / pop with
// o_soc_tenths; the oldest result is shown while empty is low and leaves on
// an edge with pop high. One result per input word, in order.
// Throughput: one word per cycle while the result queue is not full. A word
// passes the front queue, product stage, quotient stage and result queue
// before it can be popped. The segment search settles before the front
// queue write; the offset-rise product and the reciprocal multiply each
// end in a register; the correction and final add feed the result queue.
// When the receiver stops popping, the result queue fills, the pipeline
// holds, the front queue fills and full rises; nothing is dropped.
// Reset (synchronous, i_rst_n low) empties both queues and the pipeline.
// ----------------------------------------------------------------------------
module ocv_to_soc_interpolator #(
    parameter int NUM_POINTS = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  ocvsoc_pkg::t_mv i_cell_voltage_mv,
    output logic            empty,
    input  logic            pop,
    output ocvsoc_pkg::t_soc o_soc_tenths
);

    import ocvsoc_pkg::*;

    t_seg_req req;
    logic     req_empty;
    logic     req_pop;
    t_soc     res;
    logic     res_valid;
    logic     res_full;

    ocvsoc_front #(
        .NUM_POINTS (NUM_POINTS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_mv    (i_cell_voltage_mv),
        .o_full  (full),
        .i_pop   (req_pop),
        .o_req   (req),
        .o_empty (req_empty)
    );

    ocvsoc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_req_valid (!req_empty),
        .o_req_pop   (req_pop),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_full  (res_full)
    );

    ocvsoc_fifo #(
        .W     (SOC_W),
        .DEPTH (2)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_soc_tenths),
        .o_empty (empty)
    );

endmodule

// File: hw/rtl/ocvsoc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocvsoc_fifo
// Small register queue with push/full and pop/empty on its two sides.
// ----------------------------------------------------------------------------
module ocvsoc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/ocvsoc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocvsoc_front
// Compares the voltage against all breakpoints, picks the segment and the
// offset into it, and queues the classified word for the back end.
// ----------------------------------------------------------------------------
module ocvsoc_front
    import ocvsoc_pkg::t_mv;
    import ocvsoc_pkg::t_seg_req;
#(
    parameter int NUM_POINTS = 10
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_mv      i_mv,
    output logic     o_full,
    input  logic     i_pop,
    output t_seg_req o_req,
    output logic     o_empty
);

    import ocvsoc_pkg::*;

    localparam int NP_EFF = (NUM_POINTS > ROM_LEN) ? ROM_LEN : NUM_POINTS;

    t_seg_req             req;
    logic                 found;
    t_seg                 seg;
    logic [REQ_W-1:0]     q_out;

    always_comb begin
        found = 1'b0;
        seg   = '0;
        // walk downward so the lowest matching breakpoint wins
        for (int k = ROM_LEN - 1; k >= 1; k--) begin
            if ((k < NP_EFF) && (i_mv <= BP_MV[k])) begin
                found = 1'b1;
                seg   = SEG_W'(k);
            end
        end
        req.seg = seg;
        req.d   = D_W'(i_mv - BP_MV[seg - SEG_W'(1)]);
        if (i_mv <= BP_MV[0]) begin
            req.cls = CLS_LOW;
        end else if (found) begin
            req.cls = CLS_SEG;
        end else begin
            req.cls = CLS_FULL;
        end
    end

    ocvsoc_fifo #(
        .W     (REQ_W),
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (req),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (q_out),
        .o_empty (o_empty)
    );

    assign o_req = t_seg_req'(q_out);

endmodule

// File: hw/rtl/ocvsoc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocvsoc_back
// Interpolation pipeline: offset times rise, reciprocal multiply for the
// divide by span, one correction step, then the lower charge is added.
// ----------------------------------------------------------------------------
module ocvsoc_back
    import ocvsoc_pkg::t_seg_req;
    import ocvsoc_pkg::t_soc;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_seg_req i_req,
    input  logic     i_req_valid,
    output logic     o_req_pop,
    output t_soc     o_res,
    output logic     o_res_valid,
    input  logic     i_res_full
);

    import ocvsoc_pkg::*;

    // stage 1: product of offset and rise
    logic             r_v1;
    t_cls             r_cls1;
    t_seg             r_seg1;
    logic [P_W-1:0]   r_p1;
    // stage 2: quotient estimate
    logic             r_v2;
    t_cls             r_cls2;
    t_seg             r_seg2;
    logic [P_W-1:0]   r_p2;
    logic [Q_W-1:0]   r_q2;

    logic             en;
    logic [T_W-1:0]   t_prod;
    logic [P_W-1:0]   rem;
    logic [Q_W-1:0]   q_fix;
    logic [SPAN_W-1:0] span2;
    t_soc             lo_soc;

    assign en          = !r_v2 || !i_res_full;
    assign o_req_pop   = en && i_req_valid;
    assign o_res_valid = r_v2;
    assign t_prod      = T_W'(r_p1) * T_W'(SEG_RECIP[r_seg1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_req_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cls1 <= i_req.cls;
            r_seg1 <= i_req.seg;
            r_p1   <= P_W'(i_req.d) * P_W'(SEG_RISE[i_req.seg]);
            r_cls2 <= r_cls1;
            r_seg2 <= r_seg1;
            r_p2   <= r_p1;
            r_q2   <= Q_W'(t_prod >> RECIP_SH);
        end
    end

    always_comb begin
        span2  = SEG_SPAN[r_seg2];
        lo_soc = BP_SOC[r_seg2 - SEG_W'(1)];
        rem    = r_p2 - P_W'(P_W'(r_q2) * P_W'(span2));
        q_fix  = (rem >= P_W'(span2)) ? r_q2 + 1'b1 : r_q2;
        unique case (r_cls2)
            CLS_LOW:  o_res = BP_SOC[0];
            CLS_SEG: begin
                if (span2 == '0) begin
                    o_res = lo_soc;
                end else begin
                    o_res = lo_soc + SOC_W'(q_fix);
                end
            end
            CLS_FULL: o_res = SOC_FULL;
            default:  o_res = SOC_FULL;
        endcase
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives cell voltages into the voltage to charge interpolator and checks
// every returned charge word against a predicted piecewise-linear lookup.
// Runs a directed set of breakpoint and range-edge voltages, then random
// voltages under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module testbench;

    import ocvsoc_pkg::t_mv;
    import ocvsoc_pkg::t_soc;

    localparam int TBL_N = 10;
    localparam int unsigned FULL_SCALE = 1000;
    localparam int RANDOM_WORDS = 270;
    localparam int SETTLE_CYCLES = 8;

    localparam int unsigned TBL_MV [TBL_N] = '{
        3000, 3300, 3500, 3650, 3750, 3850, 3950, 4050, 4150, 4200
    };
    localparam int unsigned TBL_SOC [TBL_N] = '{
        0, 50, 120, 250, 400, 550, 700, 850, 950, 1000
    };

    localparam int DIRECTED_N = 24;
    localparam int unsigned DIRECTED_MV [DIRECTED_N] = '{
        0, 65535, 2999, 3000, 3001, 3150, 3299, 3300, 3301, 3500,
        3575, 3650, 3700, 3750, 3850, 3950, 4050, 4149, 4150, 4175,
        4199, 4200, 4201, 32768
    };

    typedef struct {
        t_mv  mv;
        t_soc soc;
    } t_soc_expect;

    class soc_board;
        t_soc_expect soc_due[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function t_soc soc_from_mv(t_mv v);
            int unsigned volts;
            int unsigned span;
            int unsigned rise;
            int unsigned r;
            volts = v;
            if (volts <= TBL_MV[0]) begin
                return t_soc'(TBL_SOC[0]);
            end
            for (int k = 1; k < TBL_N; k++) begin
                if (volts <= TBL_MV[k]) begin
                    span = TBL_MV[k] - TBL_MV[k-1];
                    rise = TBL_SOC[k] - TBL_SOC[k-1];
                    r = TBL_SOC[k-1];
                    // a flat segment keeps the lower charge
                    if (span != 0) begin
                        r += ((volts - TBL_MV[k-1]) * rise) / span;
                    end
                    return t_soc'(r);
                end
            end
            return t_soc'(FULL_SCALE);
        endfunction

        function void note_word(t_mv v);
            t_soc_expect e;
            e.mv = v;
            e.soc = soc_from_mv(v);
            soc_due.push_back(e);
        endfunction

        function void check_soc(t_soc got);
            t_soc_expect e;
            if (soc_due.size() == 0) begin
                $display("%0t: unexpected charge word: expected none, got %0d", $time, got);
                errors++;
                return;
            end
            e = soc_due.pop_front();
            if (got !== e.soc) begin
                $display("%0t: charge mismatch for %0d mV: expected %0d, got %0d",
                         $time, e.mv, e.soc, got);
                errors++;
            end
        endfunction

        function int pending();
            return soc_due.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    t_mv  i_cell_voltage_mv = '0;
    logic full;
    logic empty;
    t_soc o_soc_tenths;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    soc_board board;

    ocv_to_soc_interpolator DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_cell_voltage_mv (i_cell_voltage_mv),
        .empty             (empty),
        .pop               (pop),
        .o_soc_tenths      (o_soc_tenths)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("FAIL ocv_to_soc_interpolator");
        $finish;
    end

    // receiver: takes a word when pop meets a nonempty queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                board.check_soc(o_soc_tenths);
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_word(input t_mv v);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_cell_voltage_mv <= v;
        do begin
            @(posedge i_clk);
        end while (full);
        board.note_word(v);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int unsigned v;
        board = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_N; i++) begin
            send_word(t_mv'(DIRECTED_MV[i]));
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            for (int i = 0; i < RANDOM_WORDS; i++) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: v = $urandom_range(4300, 2900);
                    6, 7: v = TBL_MV[$urandom_range(TBL_N - 1)] + $urandom_range(4) - 2;
                    default: v = $urandom_range(65535);
                endcase
                send_word(t_mv'(v));
            end
            // hold the sender until the pipeline has emptied
            if (phase == 1) begin
                drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.pending() != 0) begin
            $display("%0t: %0d charge words never arrived", $time, board.pending());
        end
        if (board.errors == 0 && board.pending() == 0) begin
            $display("PASS ocv_to_soc_interpolator");
        end else begin
            $display("FAIL ocv_to_soc_interpolator");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/ocvsoc_pkg.sv
hw/rtl/ocvsoc_fifo.sv
hw/rtl/ocvsoc_front.sv
hw/rtl/ocvsoc_back.sv
hw/rtl/ocv_to_soc_interpolator.sv
verif/testbench.sv
